// ----- src/nts_pkg.sv -----
`default_nettype none

package nts_pkg;

  // width of the reported feature index
  localparam int unsigned IDX_W = 5;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_NOISE = 2'd1,
    STAT_NO_REAL  = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_e;

  // controller states
  typedef enum logic {
    ST_LOAD = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // insert the incoming real score
    logic pop;  // shift the chain one place toward the head
    logic clr;  // drop all entries
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/nts_cell.sv -----
`default_nettype none

module nts_cell #(
  parameter int unsigned SW = 32,
  parameter int unsigned IW = 5
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire nts_pkg::cell_ctrl_t    ctrl_i,
  input  wire logic signed [SW-1:0]   new_score_i,
  input  wire logic        [IW-1:0]   new_idx_i,
  input  wire logic                   thr_seen_i,
  input  wire logic signed [SW-1:0]   thr_i,
  input  wire logic                   left_keep_i,
  input  wire logic                   left_valid_i,
  input  wire logic signed [SW-1:0]   left_score_i,
  input  wire logic        [IW-1:0]   left_idx_i,
  input  wire logic                   right_valid_i,
  input  wire logic signed [SW-1:0]   right_score_i,
  input  wire logic        [IW-1:0]   right_idx_i,
  output logic                        keep_o,
  output logic                        pass_o,
  output logic                        valid_o,
  output logic signed [SW-1:0]        score_o,
  output logic        [IW-1:0]        idx_o
);
  import nts_pkg::*;

  logic                 valid_q, valid_d;
  logic signed [SW-1:0] score_q, score_d;
  logic        [IW-1:0] idx_q, idx_d;

  // an entry ranked at or above the new score stays in place
  assign keep_o  = valid_q && (score_q >= new_score_i);
  // strictly above the noise maximum
  assign pass_o  = valid_q && thr_seen_i && (score_q > thr_i);
  assign valid_o = valid_q;
  assign score_o = score_q;
  assign idx_o   = idx_q;

  // clear, hold, take the new entry, take the left neighbor or take the right one
  always_comb begin
    valid_d = valid_q;
    score_d = score_q;
    idx_d   = idx_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctrl_i.pop) begin
      valid_d = right_valid_i;
      score_d = right_score_i;
      idx_d   = right_idx_i;
    end else if (ctrl_i.ins && !keep_o) begin
      if (left_keep_i) begin
        valid_d = 1'b1;
        score_d = new_score_i;
        idx_d   = new_idx_i;
      end else begin
        valid_d = left_valid_i;
        score_d = left_score_i;
        idx_d   = left_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    idx_q   <= idx_d;
  end

endmodule

`default_nettype wire

// ----- src/noise_threshold_ranked_select.sv -----
`default_nettype none

// Noise-threshold ranked selection. Scores arrive one per transfer on the
// slave side (tuser high marks a noise score, tlast closes the set) and are
// taken at one per cycle: noise scores update a running maximum, real scores
// are inserted into a row of MAX_REAL_FEATURES sorting cells, each comparing
// the new score against its own entry and shifting toward the tail in the same
// cycle, so equal scores keep arrival order. After the transfer with tlast the
// slave side stalls while the chain shifts toward the head, one result per
// cycle on the master side while it does not stall: every real feature
// strictly above the noise maximum, best first, or a single none_selected
// result. Real scores beyond MAX_REAL_FEATURES are dropped and flag status 3
// on every result of the run, unless no noise score was seen (status 1).
module noise_threshold_ranked_select #(
  parameter int unsigned MAX_REAL_FEATURES = 32,
  parameter int unsigned SCORE_WIDTH       = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // score
  input  wire logic [((SCORE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // is_noise
  input  wire logic                    s_axis_tuser,
  // last
  input  wire logic                    s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // feature_index, feature_score, noise maximum
  output logic [((nts_pkg::IDX_W+2*SCORE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // none_selected, status
  output logic [2:0]                   m_axis_tuser,
  // final_res
  output logic                         m_axis_tlast
);
  import nts_pkg::*;

  localparam int unsigned N      = MAX_REAL_FEATURES;
  localparam int unsigned SW     = SCORE_WIDTH;
  localparam int unsigned IW     = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CW     = $clog2(N + 1);
  localparam int unsigned OUT_F  = IDX_W + 2 * SW;
  localparam int unsigned OUT_W  = ((OUT_F + 7) / 8) * 8;
  localparam logic signed [SW-1:0] MOST_NEG = {1'b1, {(SW-1){1'b0}}};

  state_e               state_q, state_d;
  logic signed [SW-1:0] nmax_q, nmax_d;
  logic                 seen_q, seen_d;
  logic                 ovf_q, ovf_d;
  logic [CW-1:0]        count_q, count_d;
  cell_ctrl_t           ctrl;

  logic                 s_fire;
  logic signed [SW-1:0] in_score;
  status_e              status;
  logic                 sel_ok;
  logic                 head_take;
  logic                 next_take;
  logic                 out_load;

  // output register
  logic                 ovalid_q, ovalid_d;
  logic [IDX_W-1:0]     oidx_q, oidx_d;
  logic signed [SW-1:0] oscore_q, oscore_d;
  logic signed [SW-1:0] othr_q, othr_d;
  logic                 onone_q, onone_d;
  status_e              ostat_q, ostat_d;
  logic                 ofin_q, ofin_d;

  // chain wiring
  logic                 c_keep  [N];
  logic                 c_pass  [N];
  logic                 c_valid [N];
  logic signed [SW-1:0] c_score [N];
  logic        [IW-1:0] c_idx   [N];

  assign in_score = SW'(s_axis_tdata);
  assign s_fire   = s_axis_tvalid && s_axis_tready;

  // sorting cells, head at index 0
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                 l_keep, l_valid, r_valid;
    logic signed [SW-1:0] l_score, r_score;
    logic        [IW-1:0] l_idx, r_idx;
    if (i == 0) begin : g_head
      assign l_keep  = 1'b1;
      assign l_valid = 1'b0;
      assign l_score = '0;
      assign l_idx   = '0;
    end else begin : g_mid
      assign l_keep  = c_keep[i-1];
      assign l_valid = c_valid[i-1];
      assign l_score = c_score[i-1];
      assign l_idx   = c_idx[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_score = '0;
      assign r_idx   = '0;
    end else begin : g_body
      assign r_valid = c_valid[i+1];
      assign r_score = c_score[i+1];
      assign r_idx   = c_idx[i+1];
    end
    nts_cell #(.SW(SW), .IW(IW)) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_score_i  (in_score),
      .new_idx_i    (IW'(count_q)),
      .thr_seen_i   (seen_q),
      .thr_i        (nmax_q),
      .left_keep_i  (l_keep),
      .left_valid_i (l_valid),
      .left_score_i (l_score),
      .left_idx_i   (l_idx),
      .right_valid_i(r_valid),
      .right_score_i(r_score),
      .right_idx_i  (r_idx),
      .keep_o       (c_keep[i]),
      .pass_o       (c_pass[i]),
      .valid_o      (c_valid[i]),
      .score_o      (c_score[i]),
      .idx_o        (c_idx[i])
    );
  end

  // status of the finished set
  always_comb begin
    if (!seen_q) begin
      status = STAT_NO_NOISE;
    end else if (count_q == '0) begin
      status = STAT_NO_REAL;
    end else if (ovf_q) begin
      status = STAT_OVERFLOW;
    end else begin
      status = STAT_OK;
    end
  end

  assign sel_ok    = (status == STAT_OK) || (status == STAT_OVERFLOW);
  assign head_take = sel_ok && c_pass[0];
  if (N > 1) begin : g_next
    assign next_take = sel_ok && c_pass[1];
  end else begin : g_no_next
    assign next_take = 1'b0;
  end
  assign out_load = !ovalid_q || m_axis_tready;

  // controller: load phase, then drain phase
  always_comb begin
    state_d   = state_q;
    nmax_d    = nmax_q;
    seen_d    = seen_q;
    ovf_d     = ovf_q;
    count_d   = count_q;
    ctrl      = '0;
    ovalid_d  = ovalid_q && !m_axis_tready;
    oidx_d    = oidx_q;
    oscore_d  = oscore_q;
    othr_d    = othr_q;
    onone_d   = onone_q;
    ostat_d   = ostat_q;
    ofin_d    = ofin_q;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (s_fire) begin
          if (s_axis_tuser) begin
            seen_d = 1'b1;
            if (!seen_q || in_score > nmax_q) begin
              nmax_d = in_score;
            end
          end else if (count_q == CW'(N)) begin
            ovf_d = 1'b1;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CW'(1);
          end
          if (s_axis_tlast) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          ovalid_d = 1'b1;
          othr_d   = nmax_q;
          ostat_d  = status;
          if (head_take) begin
            oidx_d   = IDX_W'(c_idx[0]);
            oscore_d = c_score[0];
            onone_d  = 1'b0;
            ofin_d   = !next_take;
            ctrl.pop = 1'b1;
          end else begin
            // nothing passed the threshold or the set is unusable
            oidx_d   = '0;
            oscore_d = '0;
            onone_d  = 1'b1;
            ofin_d   = 1'b1;
          end
          if (!head_take || !next_take) begin
            ctrl.clr = 1'b1;
            nmax_d   = MOST_NEG;
            seen_d   = 1'b0;
            ovf_d    = 1'b0;
            count_d  = '0;
            state_d  = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      nmax_q   <= MOST_NEG;
      seen_q   <= 1'b0;
      ovf_q    <= 1'b0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      nmax_q   <= nmax_d;
      seen_q   <= seen_d;
      ovf_q    <= ovf_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oidx_q   <= oidx_d;
    oscore_q <= oscore_d;
    othr_q   <= othr_d;
    onone_q  <= onone_d;
    ostat_q  <= ostat_d;
    ofin_q   <= ofin_d;
  end

  // master side packing
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = OUT_W'({othr_q, oscore_q, oidx_q});
  assign m_axis_tuser  = {ostat_q, onone_q};
  assign m_axis_tlast  = ofin_q;

  // entry count never runs past the chain length
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(N))
    else $error("real entry count above chain length");

  // a real score dropped on a full chain raises the overflow flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !s_axis_tuser && count_q == CW'(N) && !s_axis_tlast) |=> ovf_q)
    else $error("dropped real score did not flag overflow");

  // a selected feature lies strictly above the threshold it is shown with
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !onone_q) |-> (oscore_q > othr_q))
    else $error("selected score not above noise threshold");

  // draining starts only after the closing item of a set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && $past(state_q) == ST_LOAD) |-> $past(s_fire && s_axis_tlast))
    else $error("drain phase entered without a closing item");

endmodule

`default_nettype wire
